>>> rtl/rreq_pkg.sv
package rreq_pkg;

	// Fixed widths of the item fields.
	localparam int QIDX_W      = 3;
	localparam int HANDLE_W    = 8;
	localparam int PORT_W      = 4;
	localparam int SLOT_PORT_W = PORT_W + 1;

	// Operation codes carried by an input item.
	localparam logic OP_ENQUEUE = 1'b0;
	localparam logic OP_DEQUEUE = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic enq_en;
		logic deq_start;
		logic deq_finish;
	} rreq_cmd_t;

endpackage

>>> rtl/rreq_ram.sv
module rreq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port and one registered read port; read data holds when not enabled.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/rreq_dp.sv
module rreq_dp #(
	parameter int QUEUE_COUNT  = 8,
	parameter int HANDLE_SLOTS = 256,
	parameter int PORT_COUNT   = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rreq_pkg::rreq_cmd_t             cmd,
	input  logic [rreq_pkg::QIDX_W-1:0]     queue_index,
	input  logic [rreq_pkg::HANDLE_W-1:0]   packet_handle,
	input  logic                            port_valid,
	input  logic [rreq_pkg::PORT_W-1:0]     out_port,
	output logic                            served,
	output logic [rreq_pkg::QIDX_W-1:0]     served_queue,
	output logic [rreq_pkg::HANDLE_W-1:0]   served_handle,
	output logic                            transmit,
	output logic [rreq_pkg::PORT_W-1:0]     tx_port,
	output logic                            release_res
);

	import rreq_pkg::*;

	localparam int QW = $clog2(QUEUE_COUNT);
	localparam int HW = $clog2(HANDLE_SLOTS);
	localparam logic [QW-1:0] Q_TOP = QW'(QUEUE_COUNT - 1);

	// Queue descriptors and scan state.
	logic [HW-1:0]          head_q [QUEUE_COUNT];
	logic [HW-1:0]          tail_q [QUEUE_COUNT];
	logic [QUEUE_COUNT-1:0] nonempty_q;
	logic [QW-1:0]          ptr_q;

	// Dequeue in flight.
	logic [QW-1:0] deq_q_q;
	logic [HW-1:0] deq_hd_q;
	logic          deq_hit_q;
	logic          deq_last_q;

	// Result register.
	logic                served_q;
	logic [QIDX_W-1:0]   served_queue_q;
	logic [HANDLE_W-1:0] served_handle_q;
	logic                transmit_q;
	logic [PORT_W-1:0]   tx_port_q;

	logic [31:0]            q_ext;
	logic [31:0]            h_ext;
	logic                   q_ok;
	logic                   h_ok;
	logic                   p_ok;
	logic [QW-1:0]          in_q;
	logic [HW-1:0]          in_h;
	logic                   enq_do;
	logic [QW-1:0]          cand;
	logic [QW-1:0]          srch_q;
	logic                   srch_hit;
	logic [QW-1:0]          rd_q;
	logic [HW-1:0]          rd_head;
	logic [HW-1:0]          rd_tail;
	logic                   rd_ne;
	logic [HW-1:0]          link_rdata;
	logic [SLOT_PORT_W-1:0] port_rdata;

	// Range checks on the enqueue fields.
	assign q_ext  = 32'(queue_index);
	assign h_ext  = 32'(packet_handle);
	assign q_ok   = q_ext < QUEUE_COUNT;
	assign h_ok   = h_ext < HANDLE_SLOTS;
	assign p_ok   = 32'(out_port) < PORT_COUNT;
	assign in_q   = q_ext[QW-1:0];
	assign in_h   = h_ext[HW-1:0];
	assign enq_do = cmd.enq_en & q_ok & h_ok;

	// Round-robin search: first non-empty queue scanning down from the pointer.
	always_comb begin
		srch_hit = 1'b0;
		srch_q   = Q_TOP;
		cand     = '0;
		for (int k = QUEUE_COUNT - 1; k >= 0; k--) begin
			if (32'(ptr_q) >= k) begin
				cand = QW'(32'(ptr_q) - k);
			end else begin
				cand = QW'(32'(ptr_q) + QUEUE_COUNT - k);
			end
			if (nonempty_q[cand]) begin
				srch_hit = 1'b1;
				srch_q   = cand;
			end
		end
	end

	// One descriptor read per cycle: the found queue on dequeue, else the target queue.
	assign rd_q    = cmd.deq_start ? srch_q : in_q;
	assign rd_head = head_q[rd_q];
	assign rd_tail = tail_q[rd_q];
	assign rd_ne   = nonempty_q[rd_q];

	// Link store: the old tail points at the appended handle.
	rreq_ram #(
		.WIDTH (HW),
		.DEPTH (HANDLE_SLOTS)
	) u_link_ram (
		.clk   (clk),
		.we    (enq_do & rd_ne),
		.waddr (rd_tail),
		.wdata (in_h),
		.re    (cmd.deq_start),
		.raddr (rd_head),
		.rdata (link_rdata)
	);

	// Port store: valid bit over the port number, per handle.
	rreq_ram #(
		.WIDTH (SLOT_PORT_W),
		.DEPTH (HANDLE_SLOTS)
	) u_port_ram (
		.clk   (clk),
		.we    (enq_do),
		.waddr (in_h),
		.wdata ({port_valid & p_ok, out_port}),
		.re    (cmd.deq_start),
		.raddr (rd_head),
		.rdata (port_rdata)
	);

	// Non-empty marks and scan pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nonempty_q <= '0;
			ptr_q      <= Q_TOP;
		end else begin
			if (enq_do && !rd_ne) begin
				nonempty_q[in_q] <= 1'b1;
			end
			if (cmd.deq_start) begin
				if (srch_hit) begin
					if (rd_head == rd_tail) begin
						nonempty_q[srch_q] <= 1'b0;
					end
					ptr_q <= (srch_q == '0) ? Q_TOP : srch_q - 1'b1;
				end else begin
					ptr_q <= Q_TOP;
				end
			end
		end
	end

	// Heads, tails, dequeue context and the result register.
	always_ff @(posedge clk) begin
		if (enq_do) begin
			tail_q[in_q] <= in_h;
			if (!rd_ne) begin
				head_q[in_q] <= in_h;
			end
		end
		if (cmd.deq_start) begin
			deq_q_q    <= srch_q;
			deq_hd_q   <= rd_head;
			deq_hit_q  <= srch_hit;
			deq_last_q <= rd_head == rd_tail;
		end
		if (cmd.deq_finish) begin
			if (deq_hit_q && !deq_last_q) begin
				head_q[deq_q_q] <= link_rdata;
			end
			served_q        <= deq_hit_q;
			served_queue_q  <= deq_hit_q ? QIDX_W'(deq_q_q) : '0;
			served_handle_q <= deq_hit_q ? HANDLE_W'(deq_hd_q) : '0;
			transmit_q      <= deq_hit_q & port_rdata[PORT_W];
			tx_port_q       <= deq_hit_q ? port_rdata[PORT_W-1:0] : '0;
		end
	end

	assign served        = served_q;
	assign served_queue  = served_queue_q;
	assign served_handle = served_handle_q;
	assign transmit      = transmit_q;
	assign tx_port       = tx_port_q;
	assign release_res   = served_q;

endmodule

>>> rtl/rreq_ctrl.sv
module rreq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                operation,
	input  logic                rsp_stall,
	output logic                req_stall,
	output logic                rsp_valid,
	output rreq_pkg::rreq_cmd_t cmd
);

	import rreq_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DEQ  = 1'b1;

	logic state_q;
	logic state_d;
	logic rsp_valid_q;
	logic accept;
	logic out_free;

	// Items are taken only while no dequeue is in flight.
	assign req_stall = state_q != ST_IDLE;
	assign accept    = req_valid & ~req_stall;
	assign out_free  = ~rsp_valid_q | ~rsp_stall;

	// Commands to the datapath.
	assign cmd.enq_en     = accept & (operation == OP_ENQUEUE);
	assign cmd.deq_start  = accept & (operation == OP_DEQUEUE);
	assign cmd.deq_finish = (state_q == ST_DEQ) & out_free;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.deq_start) begin
					state_d = ST_DEQ;
				end
			end
			ST_DEQ: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State and result-valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.deq_finish) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

>>> rtl/round_robin_egress_queues_core.sv
// Round-robin egress scheduler: QUEUE_COUNT FIFO queues of packet handles share
// one linked-list store of HANDLE_SLOTS entries. An enqueue item appends a handle
// with its port to a queue and gives no result; out-of-range queue or handle
// numbers are dropped, and a port number at or above PORT_COUNT is stored as not
// valid. A dequeue item serves the next non-empty queue scanning downward from a
// wrapping pointer and gives one result; with every queue empty the result has
// served low and all other fields zero. A dequeue reads the link and port stores
// at the head slot through their registered read port, then loads the result
// register once it is free of rsp_stall. No new item is taken during a dequeue.
// The stores need no clearing after reset: only entries already written are read.
module round_robin_egress_queues_core #(
	parameter int QUEUE_COUNT  = 8,
	parameter int HANDLE_SLOTS = 256,
	parameter int PORT_COUNT   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic                          operation,
	input  logic [rreq_pkg::QIDX_W-1:0]   queue_index,
	input  logic [rreq_pkg::HANDLE_W-1:0] packet_handle,
	input  logic                          port_valid,
	input  logic [rreq_pkg::PORT_W-1:0]   out_port,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic                          served,
	output logic [rreq_pkg::QIDX_W-1:0]   served_queue,
	output logic [rreq_pkg::HANDLE_W-1:0] served_handle,
	output logic                          transmit,
	output logic [rreq_pkg::PORT_W-1:0]   tx_port,
	output logic                          release_res
);

	import rreq_pkg::*;

	rreq_cmd_t cmd;

	// Sequencer.
	rreq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.operation (operation),
		.rsp_stall (rsp_stall),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.cmd       (cmd)
	);

	// Queue state, stores and result register.
	rreq_dp #(
		.QUEUE_COUNT  (QUEUE_COUNT),
		.HANDLE_SLOTS (HANDLE_SLOTS),
		.PORT_COUNT   (PORT_COUNT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.queue_index   (queue_index),
		.packet_handle (packet_handle),
		.port_valid    (port_valid),
		.out_port      (out_port),
		.served        (served),
		.served_queue  (served_queue),
		.served_handle (served_handle),
		.transmit      (transmit),
		.tx_port       (tx_port),
		.release_res   (release_res)
	);

`ifndef SYNTHESIS
	// A dequeue item blocks the input for the following cycle.
	a_deq_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall && operation == OP_DEQUEUE) |=> req_stall)
		else $error("input not stalled after a dequeue item");

	// A result appears only when a dequeue finishes.
	a_rsp_from_deq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(cmd.deq_finish))
		else $error("result without a finished dequeue");

	// An empty-scheduler result carries no handle, no transmit and no release.
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !served) |-> (served_handle == '0 && !transmit && !release_res))
		else $error("empty result carries packet data");
`endif

endmodule

>>> dv/tb.sv
module tb;
	import rreq_pkg::*;

	localparam int QUEUE_COUNT     = 8;
	localparam int HANDLE_SLOTS    = 256;
	localparam int PORT_COUNT      = 16;
	localparam int RANDOM_ITEMS    = 950;
	localparam int SEGMENT_ITEMS   = 50;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int SETTLE_CYCLES   = 20;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int MAX_LIVE        = 200;
	localparam int MAX_REPORTS     = 10;

	// One request item as the sender offers it, with the idle cycles drawn before it.
	typedef struct {
		logic                op;
		logic [QIDX_W-1:0]   qidx;
		logic [HANDLE_W-1:0] handle;
		logic                pv;
		logic [PORT_W-1:0]   port;
		int unsigned         lead_gap;
	} request_t;

	// One departure item as the scheduler reports it.
	typedef struct packed {
		logic                served;
		logic [QIDX_W-1:0]   src_queue;
		logic [HANDLE_W-1:0] handle;
		logic                transmit;
		logic [PORT_W-1:0]   port;
		logic                release_flag;
	} departure_t;

	logic                clk;
	logic                arst_n        = 1'b0;
	logic                req_valid     = 1'b0;
	logic                req_stall;
	logic                operation     = OP_ENQUEUE;
	logic [QIDX_W-1:0]   queue_index   = '0;
	logic [HANDLE_W-1:0] packet_handle = '0;
	logic                port_valid    = 1'b0;
	logic [PORT_W-1:0]   out_port      = '0;
	logic                rsp_valid;
	logic                rsp_stall     = 1'b0;
	logic                served;
	logic [QIDX_W-1:0]   served_queue;
	logic [HANDLE_W-1:0] served_handle;
	logic                transmit;
	logic [PORT_W-1:0]   tx_port;
	logic                release_res;

	round_robin_egress_queues_core #(
		.QUEUE_COUNT (QUEUE_COUNT),
		.HANDLE_SLOTS(HANDLE_SLOTS),
		.PORT_COUNT  (PORT_COUNT)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.operation    (operation),
		.queue_index  (queue_index),
		.packet_handle(packet_handle),
		.port_valid   (port_valid),
		.out_port     (out_port),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.served       (served),
		.served_queue (served_queue),
		.served_handle(served_handle),
		.transmit     (transmit),
		.tx_port      (tx_port),
		.release_res  (release_res)
	);

	// Scheduler image kept by the testbench.
	logic [HANDLE_W-1:0]    q_head [QUEUE_COUNT];
	logic [HANDLE_W-1:0]    q_tail [QUEUE_COUNT];
	logic                   q_live [QUEUE_COUNT];
	logic [HANDLE_W-1:0]    slot_next [HANDLE_SLOTS];
	logic [SLOT_PORT_W-1:0] slot_attr [HANDLE_SLOTS];
	int                     rr_ptr;

	// Number of times each handle sits in a queue, counting items not yet offered.
	int handle_refs [HANDLE_SLOTS];

	request_t   pending[$];
	departure_t departures[$];
	request_t   offered;
	int unsigned idle_count = 0;

	int errors        = 0;
	int cycle_count   = 0;
	int hold_off_asks = 0;
	int hold_off_done = 0;
	int unsigned stall_left = 0;
	int unsigned rx_wait;
	bit rx_calm = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < QUEUE_COUNT; i++)
			q_live[i] = 1'b0;
		for (int i = 0; i < HANDLE_SLOTS; i++)
			handle_refs[i] = 0;
		rr_ptr = QUEUE_COUNT - 1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Apply one accepted item to the image and queue the departure it causes.
	task automatic schedule_item(request_t r);
		int q;
		logic [HANDLE_W-1:0] hd;
		departure_t d;
		if (r.op == OP_ENQUEUE) begin
			if (r.qidx < QUEUE_COUNT && r.handle < HANDLE_SLOTS) begin
				slot_attr[r.handle] = {(r.port < PORT_COUNT) ? r.pv : 1'b0, r.port};
				if (!q_live[r.qidx]) begin
					q_head[r.qidx] = r.handle;
					q_tail[r.qidx] = r.handle;
					q_live[r.qidx] = 1'b1;
				end else begin
					slot_next[q_tail[r.qidx]] = r.handle;
					q_tail[r.qidx] = r.handle;
				end
			end
		end else begin
			d = '0;
			q = rr_ptr;
			for (int k = 0; k < QUEUE_COUNT && !d.served; k++) begin
				if (q_live[q]) begin
					hd = q_head[q];
					if (hd == q_tail[q])
						q_live[q] = 1'b0;
					else
						q_head[q] = slot_next[hd];
					d.served       = 1'b1;
					d.src_queue    = QIDX_W'(q);
					d.handle       = hd;
					d.transmit     = slot_attr[hd][PORT_W];
					d.port         = slot_attr[hd][PORT_W-1:0];
					d.release_flag = 1'b1;
					handle_refs[hd]--;
					rr_ptr = (q == 0) ? QUEUE_COUNT - 1 : q - 1;
				end else begin
					q = (q == 0) ? QUEUE_COUNT - 1 : q - 1;
				end
			end
			// With every queue empty the pointer returns to the top queue.
			if (!d.served)
				rr_ptr = QUEUE_COUNT - 1;
			departures.push_back(d);
		end
	endtask

	task automatic add_enqueue(int q, int h, logic pv, int port, int unsigned gap);
		request_t r;
		r.op       = OP_ENQUEUE;
		r.qidx     = QIDX_W'(q);
		r.handle   = HANDLE_W'(h);
		r.pv       = pv;
		r.port     = PORT_W'(port);
		r.lead_gap = gap;
		handle_refs[h]++;
		pending.push_back(r);
	endtask

	task automatic add_dequeue(int q, int h, logic pv, int port, int unsigned gap);
		request_t r;
		r.op       = OP_DEQUEUE;
		r.qidx     = QIDX_W'(q);
		r.handle   = HANDLE_W'(h);
		r.pv       = pv;
		r.port     = PORT_W'(port);
		r.lead_gap = gap;
		pending.push_back(r);
	endtask

	// Hold new items back until the block has returned every departure.
	task automatic wait_until_drained();
		while (pending.size() != 0 || req_valid || departures.size() != 0)
			@(negedge clk);
	endtask

	task automatic note_error(string msg);
		if (errors < MAX_REPORTS)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
		errors++;
	endtask

	// Stimulus: a directed walk over the scan order, then random segments.
	initial begin : stimulus
		int enq_pct;
		int live;
		int h;
		int q;
		int start;
		logic [QUEUE_COUNT-1:0] qmask;
		bit tx_calm;
		int unsigned gap;

		// Dequeue with nothing queued, then fill queues at both ends of the range.
		add_dequeue(7, 255, 1'b1, 15, 0);
		add_enqueue(7, 0, 1'b1, 15, 0);
		add_enqueue(0, 255, 1'b0, 0, 0);
		add_enqueue(7, 1, 1'b0, 10, 0);
		add_enqueue(3, 128, 1'b1, 5, 0);
		// Serve 7 (head advances), 3, 0 (pointer wraps), 7 (empties), then all empty.
		add_dequeue(0, 0, 1'b0, 0, 0);
		add_dequeue(7, 255, 1'b1, 15, 0);
		add_dequeue(0, 0, 1'b0, 0, 0);
		add_dequeue(3, 170, 1'b1, 9, 0);
		add_dequeue(4, 85, 1'b0, 6, 0);
		// Queue above the pointer is reached only after the scan wraps.
		add_enqueue(5, 2, 1'b1, 3, 0);
		add_enqueue(1, 3, 1'b1, 12, 0);
		add_dequeue(0, 0, 1'b0, 0, 0);
		add_enqueue(6, 4, 1'b0, 7, 0);
		add_enqueue(2, 5, 1'b1, 0, 0);
		add_dequeue(0, 0, 1'b0, 0, 0);
		add_dequeue(0, 0, 1'b0, 0, 0);
		add_dequeue(0, 0, 1'b0, 0, 0);
		add_dequeue(0, 0, 1'b0, 0, 0);
		wait_until_drained();

		for (int seg = 0; seg * SEGMENT_ITEMS < RANDOM_ITEMS; seg++) begin
			case ($urandom_range(0, 2))
				0: enq_pct = 30;
				1: enq_pct = 55;
				default: enq_pct = 75;
			endcase
			qmask   = ($urandom_range(0, 2) == 0) ? '1 : QUEUE_COUNT'($urandom_range(1, 255));
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			// One long receiver hold-off while the sender keeps offering items.
			if (seg == 3) begin
				enq_pct = 50;
				tx_calm = 1'b1;
				rx_calm = 1'b0;
				hold_off_asks++;
			end
			for (int i = 0; i < SEGMENT_ITEMS; i++) begin
				while (pending.size() >= 4)
					@(negedge clk);
				gap = tx_calm ? 0 : $urandom_range(0, 6);
				live = 0;
				for (int k = 0; k < HANDLE_SLOTS; k++)
					if (handle_refs[k] != 0)
						live++;
				h = -1;
				if ($urandom_range(0, 99) < enq_pct && live < MAX_LIVE) begin
					start = $urandom_range(0, HANDLE_SLOTS - 1);
					for (int k = 0; k < HANDLE_SLOTS && h < 0; k++)
						if (handle_refs[(start + k) % HANDLE_SLOTS] == 0)
							h = (start + k) % HANDLE_SLOTS;
				end
				if (h >= 0) begin
					do
						q = $urandom_range(0, QUEUE_COUNT - 1);
					while (!qmask[q]);
					add_enqueue(q, h, 1'($urandom_range(0, 1)),
						$urandom_range(0, PORT_COUNT - 1), gap);
				end else begin
					add_dequeue($urandom_range(0, QUEUE_COUNT - 1),
						$urandom_range(0, HANDLE_SLOTS - 1), 1'($urandom_range(0, 1)),
						$urandom_range(0, PORT_COUNT - 1), gap);
				end
			end
			if (seg == 9)
				wait_until_drained();
		end

		wait_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("PASS round_robin_egress_queues_core");
		else
			$display("FAIL round_robin_egress_queues_core");
		$finish;
	end

	// Sender: present the next item once its idle gap has passed.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid     <= 1'b0;
			operation     <= OP_ENQUEUE;
			queue_index   <= '0;
			packet_handle <= '0;
			port_valid    <= 1'b0;
			out_port      <= '0;
			idle_count    <= 0;
		end else begin
			if (req_valid && !req_stall)
				schedule_item(offered);
			if (!req_valid || !req_stall) begin
				if (pending.size() != 0 && idle_count >= pending[0].lead_gap) begin
					offered = pending.pop_front();
					req_valid     <= 1'b1;
					operation     <= offered.op;
					queue_index   <= offered.qidx;
					packet_handle <= offered.handle;
					port_valid    <= offered.pv;
					out_port      <= offered.port;
					idle_count    <= 0;
				end else begin
					req_valid <= 1'b0;
					if (pending.size() != 0)
						idle_count <= idle_count + 1;
				end
			end
		end
	end

	// Receiver: a random stall after each departure, plus the requested long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall     <= 1'b0;
			stall_left    <= 0;
			hold_off_done <= 0;
		end else if (hold_off_done != hold_off_asks) begin
			hold_off_done <= hold_off_asks;
			stall_left    <= HOLD_OFF_CYCLES;
			rsp_stall     <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp_stall  <= (stall_left > 1);
		end else if (rsp_valid && !rsp_stall) begin
			rx_wait = rx_calm ? 0 : $urandom_range(0, 6);
			stall_left <= rx_wait;
			rsp_stall  <= (rx_wait > 0);
		end
	end

	// Compare each accepted departure with the oldest expected one.
	always @(posedge clk) begin : check_departures
		departure_t seen;
		departure_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			seen = {served, served_queue, served_handle, transmit, tx_port, release_res};
			if (departures.size() == 0) begin
				note_error($sformatf("unexpected departure served=%0d q=%0d h=%0d tx=%0d port=%0d rel=%0d",
					seen.served, seen.src_queue, seen.handle, seen.transmit, seen.port,
					seen.release_flag));
			end else begin
				want = departures.pop_front();
				if (seen !== want)
					note_error($sformatf({"expected served=%0d q=%0d h=%0d tx=%0d port=%0d rel=%0d,",
						" got served=%0d q=%0d h=%0d tx=%0d port=%0d rel=%0d"},
						want.served, want.src_queue, want.handle, want.transmit, want.port,
						want.release_flag, seen.served, seen.src_queue, seen.handle,
						seen.transmit, seen.port, seen.release_flag));
			end
		end
	end

	// Give up on a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL round_robin_egress_queues_core");
			$finish;
		end
	end

endmodule
